// ----- sv/sqrs_pkg.sv -----
// ----------------------------------------------------------------------------
// Stable quadratic root solver package
// Shared constants, defaults and the result status codes.
// ----------------------------------------------------------------------------
package sqrs_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam int COEF_BITS = 32;
  localparam int ROOT_BITS = 32;
  localparam int STAT_BITS = 2;

  typedef enum logic [STAT_BITS-1:0] {
    STATUS_NONE  = 2'd0,
    STATUS_FOUND = 2'd1,
    STATUS_DEGEN = 2'd2
  } status_e;

endpackage

// ----- sv/sqrs_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// Square root cell
// Resolves one root bit per enabled cycle and hands remainder, partial root
// and the remaining operand bits to the next cell.
// ----------------------------------------------------------------------------
module sqrs_sqrt_cell #(
  parameter int SQW = 33
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [SQW+1:0]   rem_i,
  input  logic [SQW-1:0]   root_i,
  input  logic [2*SQW-1:0] op_i,
  output logic [SQW+1:0]   rem_o,
  output logic [SQW-1:0]   root_o,
  output logic [2*SQW-1:0] op_o
);

  localparam int RW  = SQW + 2;
  localparam int OPW = 2 * SQW;

  logic [RW+1:0]    r2;
  logic [RW+1:0]    trial;
  logic             ge;
  logic [RW-1:0]    rem_d;
  logic [SQW-1:0]   root_d;
  logic [OPW-1:0]   op_d;

  always_comb begin
    r2     = {rem_i, op_i[OPW-1 -: 2]};
    trial  = (RW+2)'({root_i, 2'b01});
    ge     = (r2 >= trial);
    rem_d  = ge ? RW'(r2 - trial) : RW'(r2);
    root_d = {root_i[SQW-2:0], ge};
    op_d   = {op_i[OPW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      root_o <= root_d;
      op_o   <= op_d;
    end
  end

endmodule

// ----- sv/sqrs_div_cell.sv -----
// ----------------------------------------------------------------------------
// Division cell
// Resolves one quotient bit per enabled cycle by restoring division and hands
// the remainder, the numerator and quotient word and the divisor onwards.
// ----------------------------------------------------------------------------
module sqrs_div_cell #(
  parameter int NW  = 50,
  parameter int DVW = 34
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [DVW-1:0] rem_i,
  input  logic [NW-1:0]  nq_i,
  input  logic [DVW-1:0] div_i,
  output logic [DVW-1:0] rem_o,
  output logic [NW-1:0]  nq_o,
  output logic [DVW-1:0] div_o
);

  logic [DVW:0]   r2;
  logic           ge;
  logic [DVW-1:0] rem_d;
  logic [NW-1:0]  nq_d;

  always_comb begin
    r2    = {rem_i, nq_i[NW-1]};
    ge    = (r2 >= {1'b0, div_i});
    rem_d = ge ? DVW'(r2 - {1'b0, div_i}) : DVW'(r2);
    nq_d  = {nq_i[NW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      nq_o  <= nq_d;
      div_o <= div_i;
    end
  end

endmodule

// ----- sv/stable_quadratic_root_solver.sv -----
// ----------------------------------------------------------------------------
// Stable quadratic root solver
// Real roots of a*x^2 + b*x + c in signed fixed point, smaller root first.
// ----------------------------------------------------------------------------
// The block takes one coefficient word per cycle and returns one result word
// per coefficient word, in order. Its depth is set by the square root chain,
// one root bit per cell, and the two division chains, one quotient bit per
// cell. The root has E + 1 bits and each quotient E + 2 + F bits, with E the
// word width (at most 32) and F the fraction width. The whole pipeline holds
// while a result word waits to be taken.
module stable_quadratic_root_solver
  import sqrs_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // coef_a, coef_b, coef_c.
  input  logic [3*COEF_BITS-1:0] s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // low_root, high_root.
  output logic [2*ROOT_BITS-1:0] m_axis_tdata_o,
  // status, saturated.
  output logic [STAT_BITS:0]     m_axis_tuser_o
);

  localparam int E   = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int F   = FRAC_BITS;
  localparam int SQW = E + 1;
  localparam int OPW = 2 * SQW;
  localparam int MMW = E + 2;
  localparam int NW  = MMW + F;
  localparam logic [NW-1:0] LIM = NW'(1) << (E - 1);

  typedef struct packed {
    status_e        status;
    logic           an;
    logic           bn;
    logic           cn;
    logic           dzero;
    logic [E-1:0]   am;
    logic [E-1:0]   bm;
    logic [E-1:0]   cm;
  } sq_side_t;

  typedef struct packed {
    status_e        status;
    logic           dzero;
    logic           nega;
    logic           negb;
  } dv_side_t;

  typedef struct packed {
    logic           sat;
    logic [E-1:0]   val;
  } root_t;

  function automatic root_t sat_root(input logic [NW-1:0] q, input logic neg);
    root_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (q > LIM) begin
        r.sat = 1'b1;
        r.val = E'(LIM);
      end else begin
        r.val = E'(-q);
      end
    end else begin
      if (q > LIM - NW'(1)) begin
        r.sat = 1'b1;
        r.val = E'(LIM - NW'(1));
      end else begin
        r.val = E'(q);
      end
    end
    return r;
  endfunction

  logic en;
  logic out_valid_q;

  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Input split into sign and magnitude.
  logic [E-1:0] ra, rb, rc;
  assign ra = s_axis_tdata_i[E-1:0];
  assign rb = s_axis_tdata_i[COEF_BITS +: E];
  assign rc = s_axis_tdata_i[2*COEF_BITS +: E];

  logic         v1_q;
  logic         an1_q, bn1_q, cn1_q;
  logic [E-1:0] am1_q, bm1_q, cm1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      an1_q <= ra[E-1];
      bn1_q <= rb[E-1];
      cn1_q <= rc[E-1];
      am1_q <= ra[E-1] ? E'(-ra) : ra;
      bm1_q <= rb[E-1] ? E'(-rb) : rb;
      cm1_q <= rc[E-1] ? E'(-rc) : rc;
    end
  end

  // Products b*b and a*c.
  logic           v2_q;
  logic           an2_q, bn2_q, cn2_q;
  logic [E-1:0]   am2_q, bm2_q, cm2_q;
  logic [2*E-1:0] bb_d, p_d;
  logic [2*E-1:0] bb2_q, p2_q;

  assign bb_d = bm1_q * bm1_q;
  assign p_d  = am1_q * cm1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      an2_q <= an1_q;
      bn2_q <= bn1_q;
      cn2_q <= cn1_q;
      am2_q <= am1_q;
      bm2_q <= bm1_q;
      cm2_q <= cm1_q;
      bb2_q <= bb_d;
      p2_q  <= p_d;
    end
  end

  // Discriminant and square root chain.
  logic [OPW-1:0] bbx, p4, disc;
  sq_side_t       side3;

  always_comb begin
    bbx          = OPW'(bb2_q);
    p4           = OPW'({p2_q, 2'b00});
    disc         = '0;
    side3.an     = an2_q;
    side3.bn     = bn2_q;
    side3.cn     = cn2_q;
    side3.am     = am2_q;
    side3.bm     = bm2_q;
    side3.cm     = cm2_q;
    if (am2_q == '0) begin
      side3.status = STATUS_DEGEN;
    end else if (p2_q != '0 && an2_q != cn2_q) begin
      side3.status = STATUS_FOUND;
      disc         = bbx + p4;
    end else if (p4 > bbx) begin
      side3.status = STATUS_NONE;
    end else begin
      side3.status = STATUS_FOUND;
      disc         = bbx - p4;
    end
    side3.dzero = (disc == '0);
  end

  logic [SQW+1:0] sq_rem  [SQW+1];
  logic [SQW-1:0] sq_root [SQW+1];
  logic [OPW-1:0] sq_op   [SQW+1];
  sq_side_t       sq_side [SQW+1];
  logic [SQW:0]   sq_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_op[0]   <= disc;
      sq_side[0] <= side3;
    end
  end

  for (genvar i = 0; i < SQW; i++) begin : g_sqrt
    sqrs_sqrt_cell #(
      .SQW (SQW)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .op_i   (sq_op[i]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .op_o   (sq_op[i+1])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v[i+1] <= 1'b0;
      end else if (en) begin
        sq_v[i+1] <= sq_v[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_side[i+1] <= sq_side[i];
      end
    end
  end

  // Stable numerator m and the two division chains.
  sq_side_t       sqo;
  logic [MMW-1:0] mm;
  logic           mn;
  dv_side_t       side_m;

  always_comb begin
    sqo           = sq_side[SQW];
    mm            = MMW'(sq_root[SQW]) + MMW'(sqo.bm);
    mn            = !sqo.bn && (sqo.bm != '0);
    side_m.status = sqo.status;
    side_m.dzero  = sqo.dzero;
    side_m.nega   = mn != sqo.an;
    side_m.negb   = sqo.cn != mn;
  end

  logic [MMW-1:0] da_rem [NW+1];
  logic [NW-1:0]  da_nq  [NW+1];
  logic [MMW-1:0] da_div [NW+1];
  logic [MMW-1:0] db_rem [NW+1];
  logic [NW-1:0]  db_nq  [NW+1];
  logic [MMW-1:0] db_div [NW+1];
  dv_side_t       dv_side [NW+1];
  logic [NW:0]    dv_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[SQW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      da_rem[0]  <= '0;
      da_nq[0]   <= {mm, {F{1'b0}}};
      da_div[0]  <= MMW'({sqo.am, 1'b0});
      db_rem[0]  <= '0;
      db_nq[0]   <= NW'({sqo.cm, {(F + 1){1'b0}}});
      db_div[0]  <= mm;
      dv_side[0] <= side_m;
    end
  end

  for (genvar i = 0; i < NW; i++) begin : g_div
    sqrs_div_cell #(
      .NW  (NW),
      .DVW (MMW)
    ) u_cell_a (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (da_rem[i]),
      .nq_i  (da_nq[i]),
      .div_i (da_div[i]),
      .rem_o (da_rem[i+1]),
      .nq_o  (da_nq[i+1]),
      .div_o (da_div[i+1])
    );

    sqrs_div_cell #(
      .NW  (NW),
      .DVW (MMW)
    ) u_cell_b (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (db_rem[i]),
      .nq_i  (db_nq[i]),
      .div_i (db_div[i]),
      .rem_o (db_rem[i+1]),
      .nq_o  (db_nq[i+1]),
      .div_o (db_div[i+1])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v[i+1] <= 1'b0;
      end else if (en) begin
        dv_v[i+1] <= dv_v[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_side[i+1] <= dv_side[i];
      end
    end
  end

  // Sign, saturation, ordering and the output register.
  dv_side_t              dvo;
  root_t                 ra_r, rb_r;
  logic signed [E-1:0]   r0, r1;
  logic                  sat_d;
  logic [ROOT_BITS-1:0]  lo_d, hi_d;
  status_e               status_d;

  always_comb begin
    dvo      = dv_side[NW];
    ra_r     = sat_root(da_nq[NW], dvo.nega);
    rb_r     = sat_root(db_nq[NW], dvo.negb);
    status_d = dvo.status;
    sat_d    = 1'b0;
    lo_d     = '0;
    hi_d     = '0;
    r0       = ra_r.val;
    r1       = dvo.dzero ? ra_r.val : rb_r.val;
    if (dvo.status == STATUS_FOUND) begin
      sat_d = ra_r.sat || (!dvo.dzero && rb_r.sat);
      if (r0 > r1) begin
        lo_d = ROOT_BITS'(r1);
        hi_d = ROOT_BITS'(r0);
      end else begin
        lo_d = ROOT_BITS'(r0);
        hi_d = ROOT_BITS'(r1);
      end
    end
  end

  status_e              out_status_q;
  logic                 out_sat_q;
  logic [ROOT_BITS-1:0] out_lo_q, out_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_v[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_status_q <= status_d;
      out_sat_q    <= sat_d;
      out_lo_q     <= lo_d;
      out_hi_q     <= hi_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_hi_q, out_lo_q};
  assign m_axis_tuser_o  = {out_sat_q, out_status_q};

endmodule

// ----- test/stable_quadratic_root_solver_tb.sv -----
// ----------------------------------------------------------------------------
// Stable quadratic root solver testbench
// Drives coefficient words with random gaps and back-pressure, predicts every
// result word with an exact model of the root arithmetic and compares fields.
// ----------------------------------------------------------------------------
module stable_quadratic_root_solver_tb;
  import sqrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB        = FRAC_BITS_DEF;
  localparam int N_RANDOM  = 1100;
  localparam int WATCHDOG  = 20000;
  localparam int LONG_HOLD = 1500;
  localparam int HOLD_AT   = 400;

  typedef struct packed {
    logic [31:0] c;
    logic [31:0] b;
    logic [31:0] a;
  } coefs_t;

  typedef struct packed {
    status_e     status;
    logic        sat;
    logic [31:0] lo;
    logic [31:0] hi;
  } roots_t;

  typedef struct {
    coefs_t  cf;
    logic    typed;
    roots_t  r;
  } row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [3*COEF_BITS-1:0] s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [2*ROOT_BITS-1:0] m_axis_tdata_o;
  logic [STAT_BITS:0]     m_axis_tuser_o;

  roots_t pending_roots[$];
  int     n_errors = 0;
  int     n_words_in = 0;
  int     n_words_out = 0;
  int     n_found = 0;
  int     n_none = 0;
  int     n_degen = 0;
  int     n_sat = 0;
  int     idle_cycles = 0;
  logic   stim_done = 1'b0;

  stable_quadratic_root_solver dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] trunc_div_sat(logic [127:0] nmag, logic nneg,
                                                logic [127:0] dmag, logic dneg,
                                                ref logic sat);
    logic [127:0] q;
    if (dmag == 0) return '0;
    q = nmag / dmag;
    if (nneg != dneg) begin
      if (q > 128'h8000_0000) begin
        q = 128'h8000_0000;
        sat = 1'b1;
      end
      return -q[63:0];
    end else begin
      if (q > 128'h7fff_ffff) begin
        q = 128'h7fff_ffff;
        sat = 1'b1;
      end
      return q[63:0];
    end
  endfunction

  function automatic logic [127:0] floor_sqrt(logic [127:0] d);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int k = 34; k >= 0; k--) begin
      t = r | (128'd1 << k);
      if (t * t <= d) r = t;
    end
    return r;
  endfunction

  function automatic roots_t solve_roots(coefs_t cf);
    roots_t       res;
    logic         an, bn, cn, mn, sat;
    logic [127:0] am, bm, cm, bb, p4, d, s, mm;
    logic [63:0]  r0, r1, t;
    res = '{STATUS_NONE, 1'b0, 32'd0, 32'd0};
    sat = 1'b0;
    an = cf.a[31];
    bn = cf.b[31];
    cn = cf.c[31];
    am = an ? (128'h1_0000_0000 - 128'(cf.a)) : 128'(cf.a);
    bm = bn ? (128'h1_0000_0000 - 128'(cf.b)) : 128'(cf.b);
    cm = cn ? (128'h1_0000_0000 - 128'(cf.c)) : 128'(cf.c);
    if (am == 0) begin
      res.status = STATUS_DEGEN;
      return res;
    end
    bb = bm * bm;
    p4 = (am * cm) << 2;
    if (p4 != 0 && an != cn) d = bb + p4;
    else if (p4 > bb) return res;
    else d = bb - p4;
    res.status = STATUS_FOUND;
    mn = !bn && bm != 0;
    if (d == 0) begin
      r0 = trunc_div_sat(bm << FB, mn, am << 1, an, sat);
      r1 = r0;
    end else begin
      s = floor_sqrt(d);
      mm = s + bm;
      r0 = trunc_div_sat(mm << FB, mn, am << 1, an, sat);
      r1 = trunc_div_sat(cm << (FB + 1), cn, mm, mn, sat);
      if ($signed(r0) > $signed(r1)) begin
        t = r0;
        r0 = r1;
        r1 = t;
      end
    end
    res.sat = sat;
    res.lo = r0[31:0];
    res.hi = r1[31:0];
    return res;
  endfunction

  function automatic logic [31:0] random_coef();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3, 4: return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
      5: return {{12{1'b0}}, 20'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
      default: return $urandom;
    endcase
  endfunction

  function automatic coefs_t random_coefs();
    coefs_t cf;
    int     r0, r1;
    cf.a = random_coef();
    cf.b = random_coef();
    cf.c = random_coef();
    // Build from integer roots about a quarter of the time, so double roots
    // and exact factorisations occur often.
    if ($urandom_range(0, 3) == 0) begin
      r0 = $signed($urandom_range(0, 40)) - 20;
      r1 = ($urandom_range(0, 2) == 0) ? r0 : $signed($urandom_range(0, 40)) - 20;
      cf.a = 32'($signed($urandom_range(1, 8))) << FB;
      if ($urandom_range(0, 1) == 1) cf.a = -cf.a;
      cf.b = 32'(-($signed(cf.a) * (r0 + r1)));
      cf.c = 32'(longint'($signed(cf.a)) * r0 * r1);
    end
    return cf;
  endfunction

  task automatic send_word(coefs_t cf, logic typed, roots_t typed_r);
    roots_t pred;
    int     gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pred = solve_roots(cf);
    if (typed && pred != typed_r) begin
      $display("%0t: table row %h expected %p predicted %p", $time, cf, typed_r,
               pred);
      n_errors++;
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= cf;
    pending_roots.push_back(pred);
    do @(posedge clk_i); while (!s_axis_tready_o);
    n_words_in++;
  endtask

  task automatic drain();
    while (pending_roots.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    row_t   rows[$];
    roots_t nr;
    nr = '{STATUS_NONE, 1'b0, 32'd0, 32'd0};
    rows = '{
      '{'{c: 32'h0001_0000, b: 32'h0001_0000, a: 32'd0}, 1'b1,
        '{STATUS_DEGEN, 1'b0, 32'd0, 32'd0}},
      '{'{c: 32'h8000_0000, b: 32'h8000_0000, a: 32'd0}, 1'b1,
        '{STATUS_DEGEN, 1'b0, 32'd0, 32'd0}},
      '{'{c: 32'h0001_0000, b: 32'd0, a: 32'h0001_0000}, 1'b1, nr},
      '{'{c: 32'd0, b: 32'd0, a: 32'h0001_0000}, 1'b1,
        '{STATUS_FOUND, 1'b0, 32'd0, 32'd0}},
      '{'{c: 32'hfffc_0000, b: 32'd0, a: 32'h0001_0000}, 1'b1,
        '{STATUS_FOUND, 1'b0, 32'hfffe_0000, 32'h0002_0000}},
      '{'{c: 32'h0001_0000, b: 32'hfffe_0000, a: 32'h0001_0000}, 1'b1,
        '{STATUS_FOUND, 1'b0, 32'h0001_0000, 32'h0001_0000}},
      '{'{c: 32'h0006_0000, b: 32'hfffb_0000, a: 32'h0001_0000}, 1'b0, nr},
      '{'{c: 32'h7fff_ffff, b: 32'h7fff_ffff, a: 32'h7fff_ffff}, 1'b0, nr},
      '{'{c: 32'h8000_0000, b: 32'h8000_0000, a: 32'h8000_0000}, 1'b0, nr},
      '{'{c: 32'h8000_0000, b: 32'h7fff_ffff, a: 32'h7fff_ffff}, 1'b0, nr},
      '{'{c: 32'h7fff_ffff, b: 32'h8000_0000, a: 32'h8000_0000}, 1'b0, nr},
      '{'{c: 32'h7fff_ffff, b: 32'd0, a: 32'h0000_0001}, 1'b0, nr},
      '{'{c: 32'h8000_0000, b: 32'd0, a: 32'h0000_0001}, 1'b0, nr},
      '{'{c: 32'h0000_0001, b: 32'h7fff_ffff, a: 32'h0000_0001}, 1'b0, nr},
      '{'{c: 32'h0000_0001, b: 32'h8000_0000, a: 32'hffff_ffff}, 1'b0, nr},
      '{'{c: 32'hffff_ffff, b: 32'h0000_0001, a: 32'h7fff_ffff}, 1'b0, nr},
      '{'{c: 32'h0000_0000, b: 32'h0003_0000, a: 32'hffff_0000}, 1'b0, nr},
      '{'{c: 32'h0004_0000, b: 32'h0004_0000, a: 32'h0001_0000}, 1'b0, nr},
      '{'{c: 32'h5555_5555, b: 32'haaaa_aaaa, a: 32'h5555_5555}, 1'b0, nr},
      '{'{c: 32'haaaa_aaaa, b: 32'h5555_5555, a: 32'haaaa_aaaa}, 1'b0, nr}
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    foreach (rows[i]) send_word(rows[i].cf, rows[i].typed, rows[i].r);
    s_axis_tvalid_i <= 1'b0;
    drain();
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 600) begin
        s_axis_tvalid_i <= 1'b0;
        drain();
      end
      send_word(random_coefs(), 1'b0, nr);
    end
    s_axis_tvalid_i <= 1'b0;
    stim_done <= 1'b1;
  end

  initial begin
    int gap;
    int held;
    int n_taken;
    n_taken = 0;
    @(posedge rst_ni);
    forever begin
      if (n_taken == HOLD_AT) begin
        held = 0;
        m_axis_tready_i <= 1'b0;
        while (held < LONG_HOLD) begin
          @(posedge clk_i);
          held++;
        end
      end else begin
        gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
          m_axis_tready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      n_taken++;
    end
  end

  always @(posedge clk_i) begin
    roots_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_words_out++;
      if (pending_roots.size() == 0) begin
        $display("%0t: unexpected result word %h/%h", $time, m_axis_tuser_o,
                 m_axis_tdata_o);
        n_errors++;
      end else begin
        exp_r = pending_roots.pop_front();
        case (exp_r.status)
          STATUS_FOUND: n_found++;
          STATUS_DEGEN: n_degen++;
          default: n_none++;
        endcase
        if (exp_r.sat) n_sat++;
        if (m_axis_tuser_o[STAT_BITS-1:0] !== exp_r.status) begin
          $display("%0t: status expected %0d got %0d", $time, exp_r.status,
                   m_axis_tuser_o[STAT_BITS-1:0]);
          n_errors++;
        end
        if (m_axis_tuser_o[STAT_BITS] !== exp_r.sat) begin
          $display("%0t: saturated expected %b got %b", $time, exp_r.sat,
                   m_axis_tuser_o[STAT_BITS]);
          n_errors++;
        end
        if (m_axis_tdata_o[31:0] !== exp_r.lo) begin
          $display("%0t: low_root expected %h got %h", $time, exp_r.lo,
                   m_axis_tdata_o[31:0]);
          n_errors++;
        end
        if (m_axis_tdata_o[63:32] !== exp_r.hi) begin
          $display("%0t: high_root expected %h got %h", $time, exp_r.hi,
                   m_axis_tdata_o[63:32]);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (pending_roots.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d coefficient words, checked %0d results.", n_words_in,
             n_words_out);
    $display("Roots found %0d, none %0d, degenerate %0d, saturated %0d.",
             n_found, n_none, n_degen, n_sat);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
